// ===== src/msdt_pkg.sv =====
`default_nettype none
package msdt_pkg;
   localparam int CMD_BITS  = 4;
   localparam int SLOT_BITS = 4;
   localparam int IVL_BITS  = 32;
   localparam int TTN_BITS  = 48;
   localparam int MAX_RES   = 16;

   localparam logic [3:0] CMD_ADD     = 4'd0;
   localparam logic [3:0] CMD_START   = 4'd1;
   localparam logic [3:0] CMD_STOP    = 4'd2;
   localparam logic [3:0] CMD_RESTART = 4'd3;
   localparam logic [3:0] CMD_REMOVE  = 4'd4;
   localparam logic [3:0] CMD_SETIVL  = 4'd5;
   localparam logic [3:0] CMD_SHIFT   = 4'd6;
   localparam logic [3:0] CMD_TICK    = 4'd7;
   localparam logic [3:0] CMD_QUERY   = 4'd8;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INVALID  = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_UNARMED  = 2'd3;

   typedef struct packed {
      logic                 kind;
      logic [1:0]           status;
      logic [SLOT_BITS-1:0] slot;
      logic                 armed;
      logic                 queue_empty;
      logic [TTN_BITS-1:0]  ttn;
      logic                 last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== src/multi_slot_delay_timer_top.sv =====
`default_nettype none
// Timer slot table with a tick counter that each tick command advances.
// req_ channel: one command word per handshake (add, start, stop, restart,
// remove, set interval, shift deadline, tick, query).
// rsp_ channel: reply words; a tick gives one expiry word per due slot,
// up to MAX_RES, in deadline order (lowest slot on ties), or one plain
// reply; tlast marks the final word of a command.
// A command's reply follows one scan of the table by a shared compare
// unit; a tick gives each expiry word after a scan of its own.
// req_tready is low while a command is in progress; one command at a time.
// A stalled rsp_tready holds the word in the output register; the sequencer
// scans on but stalls before its next word until the held one is taken.
// Reset clears the counter and all valid and armed marks.
module multi_slot_delay_timer_top #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // cmd[3:0] slot[7:4] interval_ms[39:8] one_shot[40] auto_release[41]
   // deadline_shift[73:42], zero fill
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0] result_slot[5:2] armed[6] queue_empty[7] time_to_next[55:8]
   output logic [55:0]      rsp_tdata,
   output logic             rsp_tuser,  // kind
   output logic             rsp_tlast
);
   import msdt_pkg::*;
   logic    busy;
   rsp_type r;

   assign req_tready = !busy;

   msdt_core #(.NUM_SLOTS(NUM_SLOTS), .TIME_BITS(TIME_BITS)) u_core (
      .clock(clock), .reset(reset), .start(req_tvalid && !busy),
      .cmd(req_tdata[3:0]), .slot(req_tdata[7:4]), .interval_ms(req_tdata[39:8]),
      .one_shot(req_tdata[40]), .auto_release(req_tdata[41]),
      .deadline_shift(req_tdata[73:42]), .busy(busy),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(r)
   );

   assign rsp_tdata = {r.ttn, r.queue_empty, r.armed, r.slot, r.status};
   assign rsp_tuser = r.kind;
   assign rsp_tlast = r.last;
endmodule
`default_nettype wire

// ===== src/msdt_core.sv =====
`default_nettype none
module msdt_core #(
   parameter int NUM_SLOTS = 16,
   parameter int TIME_BITS = 48
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [3:0]                cmd,
   input  wire logic [3:0]                slot,
   input  wire logic [31:0]               interval_ms,
   input  wire logic                      one_shot,
   input  wire logic                      auto_release,
   input  wire logic [31:0]               deadline_shift,
   output logic                           busy,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output msdt_pkg::rsp_type              rsp
);
   import msdt_pkg::*;
   localparam int IB = $clog2(NUM_SLOTS);
   localparam int CB = $clog2(NUM_SLOTS + 1);
   localparam int NB = $clog2(MAX_RES + 1);
   localparam logic [TIME_BITS-1:0] TSIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_FIRE = 6'b000100,
      S_EXEC = 6'b001000, S_OUT  = 6'b010000, S_WAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in, armed_ff, armed_in, done_ff, done_in;
   logic [NUM_SLOTS-1:0] oneshot_ff, autof_ff;
   logic [31:0]          ivl_ff [NUM_SLOTS];
   logic [TIME_BITS-1:0] dl_ff  [NUM_SLOTS];
   logic [3:0]           cmd_ff;
   logic [3:0]           slot_ff;
   logic [31:0]          ivl_arg_ff, shift_ff;
   logic                 os_arg_ff, af_arg_ff;
   logic [CB-1:0]        idx_ff, idx_in;
   logic [CB-1:0]        cnt_ff, cnt_in;
   logic                 have_ff, have_in;
   logic [IB-1:0]        best_ff, best_in;
   logic [TIME_BITS-1:0] bkey_ff, bkey_in;
   logic [NB-1:0]        nfire_ff, nfire_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rv_ff, rv_in;

   logic [IB-1:0]        ci;
   logic [TIME_BITS-1:0] cgap, ckey, sgap;
   logic                 cand, ok;
   logic [IB-1:0]        si;
   logic                 wr_en;
   logic [IB-1:0]        wr_idx;
   logic [TIME_BITS-1:0] wr_dl;
   logic                 wr_add;
   logic                 wr_ivl;

   assign ci   = idx_ff[IB-1:0];
   assign cgap = dl_ff[ci] - now_ff;
   assign ckey = cgap ^ TSIGN;
   assign si   = IB'(slot_ff);
   assign ok   = ({{(32-4){1'b0}}, slot_ff} < 32'(NUM_SLOTS)) && valid_ff[si];
   assign sgap = dl_ff[si];
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp = rsp_ff;

   always_comb begin
      cand = 1'b0;
      unique case (cmd_ff)
         CMD_TICK:  cand = valid_ff[ci] && armed_ff[ci] && !done_ff[ci] &&
                           (cgap == '0 || cgap[TIME_BITS-1]);
         CMD_ADD:   cand = !valid_ff[ci];
         default:   cand = valid_ff[ci] && armed_ff[ci];
      endcase
   end

   always_comb begin
      state_in = state_ff; now_in = now_ff; valid_in = valid_ff; armed_in = armed_ff;
      done_in = done_ff; idx_in = idx_ff; have_in = have_ff; best_in = best_ff;
      bkey_in = bkey_ff; nfire_in = nfire_ff; rsp_in = rsp_ff; rv_in = rv_ff;
      cnt_in = cnt_ff;
      wr_en = 1'b0; wr_idx = si; wr_dl = '0; wr_add = 1'b0; wr_ivl = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_SCAN; idx_in = '0; have_in = 1'b0; done_in = '0;
               nfire_in = '0; cnt_in = '0;
               if (cmd == CMD_TICK) now_in = now_ff + 1'b1;
            end
         end
         S_SCAN: begin
            if (idx_ff == CB'(NUM_SLOTS)) begin
               state_in = (cmd_ff == CMD_TICK) ? S_FIRE : S_EXEC;
            end else begin
               if (cand && (!have_ff || (cmd_ff != CMD_ADD && ckey < bkey_ff))) begin
                  have_in = 1'b1; best_in = ci; bkey_in = ckey;
               end
               // first pass of a tick counts the due slots
               if (cmd_ff == CMD_TICK && nfire_ff == '0 && cand) cnt_in = cnt_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FIRE: begin
            if (!rv_ff || rsp_ready) begin
               rsp_in = '0; rv_in = 1'b1; rsp_in.last = 1'b1; state_in = S_WAIT;
               if (have_ff) begin
                  rsp_in.kind = 1'b1; rsp_in.slot = 4'(best_ff);
                  done_in[best_ff] = 1'b1; nfire_in = nfire_ff + 1'b1;
                  if (oneshot_ff[best_ff]) begin
                     armed_in[best_ff] = 1'b0;
                     if (autof_ff[best_ff]) valid_in[best_ff] = 1'b0;
                  end else begin
                     wr_en = 1'b1; wr_idx = best_ff;
                     wr_dl = now_ff + TIME_BITS'(ivl_ff[best_ff]);
                  end
                  if (nfire_ff != NB'(MAX_RES - 1) &&
                      CB'(nfire_ff) + 1'b1 != cnt_ff) begin
                     rsp_in.last = 1'b0; idx_in = '0; have_in = 1'b0; state_in = S_SCAN;
                  end
               end
            end
         end
         S_EXEC: begin
            if (!rv_ff || rsp_ready) begin
               rsp_in = '0; rsp_in.slot = slot_ff; rsp_in.last = 1'b1;
               priority case (1'b1)
                  cmd_ff == CMD_ADD: begin
                     if (!have_ff) begin rsp_in.status = ST_FULL; rsp_in.slot = '0; end
                     else begin
                        rsp_in.slot = 4'(best_ff); valid_in[best_ff] = 1'b1;
                        armed_in[best_ff] = 1'b0; wr_add = 1'b1; wr_en = 1'b1;
                        wr_idx = best_ff; wr_dl = now_ff;
                     end
                  end
                  cmd_ff == CMD_QUERY: begin
                     rsp_in.status = ok ? ST_OK : ST_INVALID;
                     rsp_in.armed = ok && armed_ff[si];
                     rsp_in.queue_empty = !have_ff;
                     rsp_in.ttn = have_ff ? TTN_BITS'($signed(bkey_ff ^ TSIGN)) : '1;
                  end
                  cmd_ff > CMD_QUERY || cmd_ff == CMD_TICK: begin
                     rsp_in.slot = '0;
                  end
                  !ok: rsp_in.status = ST_INVALID;
                  cmd_ff == CMD_START: begin
                     if (!armed_ff[si]) begin
                        armed_in[si] = 1'b1; wr_en = 1'b1;
                        wr_dl = now_ff + TIME_BITS'(ivl_ff[si]);
                     end
                  end
                  cmd_ff == CMD_STOP: begin
                     if (armed_ff[si]) begin
                        armed_in[si] = 1'b0;
                        if (autof_ff[si]) valid_in[si] = 1'b0;
                     end
                  end
                  cmd_ff == CMD_RESTART: begin
                     armed_in[si] = 1'b1; wr_en = 1'b1;
                     wr_dl = now_ff + TIME_BITS'(ivl_ff[si]);
                  end
                  cmd_ff == CMD_REMOVE: begin
                     valid_in[si] = 1'b0; armed_in[si] = 1'b0;
                  end
                  cmd_ff == CMD_SETIVL: wr_ivl = 1'b1;
                  default: begin
                     if (!armed_ff[si]) rsp_in.status = ST_UNARMED;
                     else begin
                        wr_en = 1'b1;
                        wr_dl = sgap + TIME_BITS'($signed(shift_ff));
                     end
                  end
               endcase
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_ready) begin rv_in = 1'b1; state_in = S_WAIT; end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; now_ff <= '0; valid_ff <= '0; armed_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; now_ff <= now_in; valid_ff <= valid_in;
         armed_ff <= armed_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= done_in; idx_ff <= idx_in; have_ff <= have_in; best_ff <= best_in;
      bkey_ff <= bkey_in; nfire_ff <= nfire_in; cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
      if (start && state_ff == S_IDLE) begin
         cmd_ff <= cmd; slot_ff <= slot; ivl_arg_ff <= interval_ms;
         shift_ff <= deadline_shift; os_arg_ff <= one_shot; af_arg_ff <= auto_release;
      end
      if (wr_en) dl_ff[wr_idx] <= wr_dl;
      if (wr_add) begin
         oneshot_ff[wr_idx] <= os_arg_ff; autof_ff[wr_idx] <= af_arg_ff;
         ivl_ff[wr_idx] <= ivl_arg_ff;
      end
      if (wr_ivl) ivl_ff[si] <= ivl_arg_ff;
   end
endmodule
`default_nettype wire
